/* rtl/tmn_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmn_pkg
// Shared constants and the thruster allocation table of the normalized mixer.
// ----------------------------------------------------------------------------
package tmn_pkg;

	localparam int N_AXES      = 6;
	localparam int N_LANES     = 8;
	localparam int N_GRP_LANES = 4;
	localparam int N_GROUPS    = N_LANES / N_GRP_LANES;

	localparam int AX_SURGE = 0;
	localparam int AX_SWAY  = 1;
	localparam int AX_HEAVE = 2;
	localparam int AX_ROLL  = 3;
	localparam int AX_PITCH = 4;
	localparam int AX_YAW   = 5;

	localparam int LN_H0 = 0;
	localparam int LN_H1 = 1;
	localparam int LN_H2 = 2;
	localparam int LN_H3 = 3;
	localparam int LN_V0 = 4;
	localparam int LN_V1 = 5;
	localparam int LN_V2 = 6;
	localparam int LN_V3 = 7;

	typedef enum logic [1:0] {
		COEF_ZERO,
		COEF_POS,
		COEF_NEG
	} coef_t;

	// columns: surge sway heave roll pitch yaw, each entry a quarter
	localparam coef_t MIX_COEF [N_LANES][N_AXES] = '{
		'{COEF_POS,  COEF_NEG,  COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_NEG },
		'{COEF_POS,  COEF_POS,  COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_POS },
		'{COEF_NEG,  COEF_POS,  COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_NEG },
		'{COEF_NEG,  COEF_NEG,  COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_POS },
		'{COEF_ZERO, COEF_ZERO, COEF_NEG,  COEF_NEG,  COEF_POS,  COEF_ZERO},
		'{COEF_ZERO, COEF_ZERO, COEF_NEG,  COEF_POS,  COEF_POS,  COEF_ZERO},
		'{COEF_ZERO, COEF_ZERO, COEF_NEG,  COEF_NEG,  COEF_NEG,  COEF_ZERO},
		'{COEF_ZERO, COEF_ZERO, COEF_NEG,  COEF_POS,  COEF_NEG,  COEF_ZERO}
	};

endpackage
`default_nettype wire

/* rtl/tmn_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmn_lane
// One thruster lane: signed sum of the command axes, floor divide by four,
// and the magnitude of the result.
// ----------------------------------------------------------------------------
module tmn_lane #(
	parameter int SW   = 16,
	parameter int LANE = 0
) (
	input  wire logic signed [SW-1:0] cmd [tmn_pkg::N_AXES],
	output logic signed [SW-1:0]      thr,
	output logic        [SW-2:0]      mag
);
	import tmn_pkg::*;

	logic signed [SW+2:0] acc;
	logic signed [SW+2:0] shf;
	logic signed [SW-1:0] neg;

	always_comb begin
		acc = '0;
		for (int a = 0; a < N_AXES; a++) begin
			case (MIX_COEF[LANE][a])
				COEF_POS: acc = acc + (SW+3)'(cmd[a]);
				COEF_NEG: acc = acc - (SW+3)'(cmd[a]);
				default:  acc = acc;
			endcase
		end
	end

	assign shf = acc >>> 2;
	assign thr = shf[SW-1:0];
	assign neg = -thr;
	assign mag = thr[SW-1] ? neg[SW-2:0] : thr[SW-2:0];

endmodule
`default_nettype wire

/* rtl/tmn_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmn_merge
// Largest magnitude of a group of four lanes and the flag that asks for
// scaling when it exceeds one.
// ----------------------------------------------------------------------------
module tmn_merge #(
	parameter int SW = 16,
	parameter int FB = 14
) (
	input  wire logic [SW-2:0] mag [tmn_pkg::N_GRP_LANES],
	output logic      [SW-2:0] mx,
	output logic               scale
);
	import tmn_pkg::*;

	localparam longint unsigned ONE = 64'd1 << FB;

	logic [SW-2:0] m01;
	logic [SW-2:0] m23;

	assign m01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
	assign m23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
	assign mx    = (m01 > m23) ? m01 : m23;
	assign scale = 64'(mx) > ONE;

endmodule
`default_nettype wire

/* rtl/tmn_div_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmn_div_step
// One restoring division step: compare the partial remainder with the
// divisor, subtract on success and emit one quotient bit.
// ----------------------------------------------------------------------------
module tmn_div_step #(
	parameter int SW = 16
) (
	input  wire logic [SW-1:0] part,
	input  wire logic [SW-2:0] dvsr,
	output logic               qbit,
	output logic      [SW-2:0] rem
);
	logic [SW-1:0] dext;
	logic [SW-1:0] diff;

	assign dext = {1'b0, dvsr};
	assign diff = part - dext;
	assign qbit = part >= dext;
	assign rem  = qbit ? diff[SW-2:0] : part[SW-2:0];

endmodule
`default_nettype wire

/* rtl/thruster_mixer_normalized_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thruster_mixer_normalized_core
// Six-axis command to eight thruster drives with per-group normalization.
//
// Input channel in_valid / in_stall carries one six-axis command per item;
// output channel out_valid / out_stall carries the eight drives of it.
// An item moves on a clock edge with valid high and stall low.
// Eight lanes form the signed quarter sums; a merge stage finds the largest
// magnitude of each group of four; each lane then runs a pipelined restoring
// divider, one quotient bit per stage, FRAC_BITS+1 stages.
// From the accepting edge to out_valid an item passes the lane register,
// the merge register, the divider stages and the output register. A new
// item can be taken every cycle unless the pipe is full and out_stall is
// high, so throughput is then one item per cycle.
// Every stage holds its item while the next one is full and stalled, so
// bubbles close up and input is taken as long as any stage is free; with the
// pipe full and out_stall high, in_stall rises and results wait in place.
// Reset empties the pipe; out_valid is low until the first item arrives.
// ----------------------------------------------------------------------------
module thruster_mixer_normalized_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 14
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_surge,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_sway,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_heave,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_roll,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_pitch,
	input  wire logic signed [SAMPLE_WIDTH-1:0] cmd_yaw,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_h0,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_h1,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_h2,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_h3,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_v0,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_v1,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_v2,
	output logic signed [SAMPLE_WIDTH-1:0]      thrust_v3
);
	import tmn_pkg::*;

	localparam int SW   = SAMPLE_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int NDIV = FB + 1;
	localparam int NST  = NDIV + 3;
	localparam int W    = (FB + 2 > SW) ? FB + 2 : SW;

	logic signed [SW-1:0] cmd [N_AXES];
	logic signed [SW-1:0] thr_c [N_LANES];
	logic        [SW-2:0] mag_c [N_LANES];
	logic        [SW-2:0] max_c [N_GROUPS];
	logic                 scl_c [N_GROUPS];

	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;

	logic signed [SW-1:0] thr_s1 [N_LANES];
	logic        [SW-2:0] mag_s1 [N_LANES];

	logic signed [SW-1:0] thr_s2 [N_LANES];
	logic        [SW-2:0] mag_s2 [N_LANES];
	logic        [SW-2:0] max_s2 [N_GROUPS];
	logic                 scl_s2 [N_GROUPS];

	logic signed [SW-1:0] thr_s3 [NDIV][N_LANES];
	logic        [SW-2:0] rem_s3 [NDIV][N_LANES];
	logic        [FB:0]   quo_s3 [NDIV][N_LANES];
	logic        [SW-2:0] max_s3 [NDIV][N_GROUPS];
	logic                 scl_s3 [NDIV][N_GROUPS];

	logic [SW-1:0] part_c [NDIV][N_LANES];
	logic [SW-2:0] dvsr_c [NDIV][N_LANES];
	logic          qbit_c [NDIV][N_LANES];
	logic [SW-2:0] rem_c  [NDIV][N_LANES];

	logic signed [SW-1:0] res_c [N_LANES];
	logic signed [SW-1:0] res_q [N_LANES];

	assign cmd[AX_SURGE] = cmd_surge;
	assign cmd[AX_SWAY]  = cmd_sway;
	assign cmd[AX_HEAVE] = cmd_heave;
	assign cmd[AX_ROLL]  = cmd_roll;
	assign cmd[AX_PITCH] = cmd_pitch;
	assign cmd[AX_YAW]   = cmd_yaw;

	// handshake: a stage loads when empty or when its successor moves
	always_comb begin
		rdy[NST] = !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// lanes
	for (genvar l = 0; l < N_LANES; l++) begin : g_lane
		tmn_lane #(
			.SW   (SW),
			.LANE (l)
		) u_lane (
			.cmd (cmd),
			.thr (thr_c[l]),
			.mag (mag_c[l])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			thr_s1 <= thr_c;
			mag_s1 <= mag_c;
		end
	end

	// group maximum
	for (genvar g = 0; g < N_GROUPS; g++) begin : g_grp
		logic [SW-2:0] gmag [N_GRP_LANES];

		for (genvar i = 0; i < N_GRP_LANES; i++) begin : g_sel
			assign gmag[i] = mag_s1[g*N_GRP_LANES + i];
		end

		tmn_merge #(
			.SW (SW),
			.FB (FB)
		) u_merge (
			.mag   (gmag),
			.mx    (max_c[g]),
			.scale (scl_c[g])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			thr_s2 <= thr_s1;
			mag_s2 <= mag_s1;
			max_s2 <= max_c;
			scl_s2 <= scl_c;
		end
	end

	// divider pipeline, quotient msb first
	for (genvar j = 0; j < NDIV; j++) begin : g_div
		for (genvar l = 0; l < N_LANES; l++) begin : g_dl
			if (j == 0) begin : g_first
				assign part_c[j][l] = {1'b0, mag_s2[l]};
				assign dvsr_c[j][l] = max_s2[l / N_GRP_LANES];
			end else begin : g_next
				assign part_c[j][l] = {rem_s3[j-1][l], 1'b0};
				assign dvsr_c[j][l] = max_s3[j-1][l / N_GRP_LANES];
			end

			tmn_div_step #(
				.SW (SW)
			) u_step (
				.part (part_c[j][l]),
				.dvsr (dvsr_c[j][l]),
				.qbit (qbit_c[j][l]),
				.rem  (rem_c[j][l])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int l = 0; l < N_LANES; l++) begin
				rem_s3[0][l] <= rem_c[0][l];
				thr_s3[0][l] <= thr_s2[l];
				quo_s3[0][l] <= (FB+1)'(qbit_c[0][l]);
			end
			for (int g = 0; g < N_GROUPS; g++) begin
				max_s3[0][g] <= max_s2[g];
				scl_s3[0][g] <= scl_s2[g];
			end
		end
		for (int j = 1; j < NDIV; j++) begin
			if (rdy[j+2]) begin
				for (int l = 0; l < N_LANES; l++) begin
					rem_s3[j][l] <= rem_c[j][l];
					thr_s3[j][l] <= thr_s3[j-1][l];
					quo_s3[j][l] <= {quo_s3[j-1][l][FB-1:0], qbit_c[j][l]};
				end
				for (int g = 0; g < N_GROUPS; g++) begin
					max_s3[j][g] <= max_s3[j-1][g];
					scl_s3[j][g] <= scl_s3[j-1][g];
				end
			end
		end
	end

	// sign restore, truncation toward zero
	always_comb begin
		logic [W-1:0] qx;
		logic [W-1:0] qn;
		logic [W-1:0] qs;
		for (int l = 0; l < N_LANES; l++) begin
			qx = W'(quo_s3[NDIV-1][l]);
			qn = -qx;
			qs = thr_s3[NDIV-1][l][SW-1] ? qn : qx;
			res_c[l] = scl_s3[NDIV-1][l / N_GRP_LANES] ? qs[SW-1:0] : thr_s3[NDIV-1][l];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			res_q <= res_c;
		end
	end

	assign thrust_h0 = res_q[LN_H0];
	assign thrust_h1 = res_q[LN_H1];
	assign thrust_h2 = res_q[LN_H2];
	assign thrust_h3 = res_q[LN_H3];
	assign thrust_v0 = res_q[LN_V0];
	assign thrust_v1 = res_q[LN_V1];
	assign thrust_v2 = res_q[LN_V2];
	assign thrust_v3 = res_q[LN_V3];

endmodule
`default_nettype wire

/* verif/tb_thruster_mixer_normalized_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thruster_mixer_normalized_core
// Self-checking bench for the six-axis to eight-thruster normalized mixer.
//
// Commands go in through the valid/stall input channel and drive sets come
// out through the output channel. A local model forms the signed quarter
// sums of each thruster, floors them, and scales each group of four when its
// peak magnitude is above one. Every drive set is compared lane by lane
// against the oldest prediction. Stimulus covers axis extremes, bit
// patterns, the exact-one and just-over-one boundaries, and random commands
// under mixed sender and receiver idling, a long output hold-off that backs
// up the pipe, and a full drain between bursts.
// ----------------------------------------------------------------------------
module tb_thruster_mixer_normalized_core;

	import tmn_pkg::*;

	localparam int SW          = 16;
	localparam int FB          = 14;
	localparam longint ONE     = longint'(1) << FB;
	localparam int LATENCY     = FB + 3;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 2000;

	typedef logic [N_AXES-1:0][SW-1:0]  cmd_set_t;
	typedef logic [N_LANES-1:0][SW-1:0] drive_set_t;

	// quarter signs per lane; columns surge sway heave roll pitch yaw
	localparam int QUARTER_SIGN [N_LANES][N_AXES] = '{
		'{ 1, -1,  0,  0,  0, -1},
		'{ 1,  1,  0,  0,  0,  1},
		'{-1,  1,  0,  0,  0, -1},
		'{-1, -1,  0,  0,  0,  1},
		'{ 0,  0, -1, -1,  1,  0},
		'{ 0,  0, -1,  1,  1,  0},
		'{ 0,  0, -1, -1, -1,  0},
		'{ 0,  0, -1,  1, -1,  0}
	};

	string lane_name [N_LANES] = '{"thrust_h0", "thrust_h1", "thrust_h2", "thrust_h3",
		"thrust_v0", "thrust_v1", "thrust_v2", "thrust_v3"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] cmd_surge = '0;
	logic signed [SW-1:0] cmd_sway = '0;
	logic signed [SW-1:0] cmd_heave = '0;
	logic signed [SW-1:0] cmd_roll = '0;
	logic signed [SW-1:0] cmd_pitch = '0;
	logic signed [SW-1:0] cmd_yaw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] thrust_h0, thrust_h1, thrust_h2, thrust_h3;
	logic signed [SW-1:0] thrust_v0, thrust_v1, thrust_v2, thrust_v3;

	drive_set_t expected_drives [$];
	int drive_mismatches = 0;
	int commands_taken = 0;
	int drive_sets_checked = 0;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_asks = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	thruster_mixer_normalized_core #(
		.SAMPLE_WIDTH(SW),
		.FRAC_BITS(FB)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd_surge(cmd_surge),
		.cmd_sway(cmd_sway),
		.cmd_heave(cmd_heave),
		.cmd_roll(cmd_roll),
		.cmd_pitch(cmd_pitch),
		.cmd_yaw(cmd_yaw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.thrust_h0(thrust_h0),
		.thrust_h1(thrust_h1),
		.thrust_h2(thrust_h2),
		.thrust_h3(thrust_h3),
		.thrust_v0(thrust_v0),
		.thrust_v1(thrust_v1),
		.thrust_v2(thrust_v2),
		.thrust_v3(thrust_v3)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic drive_set_t mix_and_normalize(cmd_set_t c);
		longint axis [N_AXES];
		longint lane [N_LANES];
		longint acc;
		longint peak;
		longint mag;
		drive_set_t d;
		for (int j = 0; j < N_AXES; j++)
			axis[j] = longint'($signed(c[j]));
		for (int i = 0; i < N_LANES; i++) begin
			acc = 0;
			for (int j = 0; j < N_AXES; j++)
				acc += QUARTER_SIGN[i][j] * axis[j];
			lane[i] = acc >>> 2;
		end
		for (int g = 0; g < N_GROUPS; g++) begin
			peak = 0;
			for (int k = 0; k < N_GRP_LANES; k++) begin
				mag = lane[g*N_GRP_LANES+k] < 0 ? -lane[g*N_GRP_LANES+k] : lane[g*N_GRP_LANES+k];
				if (mag > peak)
					peak = mag;
			end
			if (peak > ONE)
				for (int k = 0; k < N_GRP_LANES; k++)
					lane[g*N_GRP_LANES+k] = (lane[g*N_GRP_LANES+k] * ONE) / peak;
		end
		for (int i = 0; i < N_LANES; i++)
			d[i] = lane[i][SW-1:0];
		return d;
	endfunction

	// input capture and output check share one sampling point
	always @(posedge clk) begin
		drive_set_t got;
		drive_set_t want;
		if (in_valid && !in_stall) begin
			expected_drives.push_back(mix_and_normalize({cmd_yaw, cmd_pitch, cmd_roll,
				cmd_heave, cmd_sway, cmd_surge}));
			commands_taken++;
		end
		if (out_valid && !out_stall) begin
			got = {thrust_v3, thrust_v2, thrust_v1, thrust_v0,
				thrust_h3, thrust_h2, thrust_h1, thrust_h0};
			if (expected_drives.size() == 0) begin
				$error("drive set with no command pending");
				drive_mismatches++;
			end else begin
				want = expected_drives.pop_front();
				drive_sets_checked++;
				for (int i = 0; i < N_LANES; i++)
					if (got[i] !== want[i]) begin
						$error("%s expected %0d actual %0d", lane_name[i],
							$signed(want[i]), $signed(got[i]));
						drive_mismatches++;
					end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_asks != hold_taken) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("thruster_mixer_normalized_core regression: fail");
			$finish;
		end
	end

	task automatic send_command(input cmd_set_t c);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		cmd_surge = c[0];
		cmd_sway  = c[1];
		cmd_heave = c[2];
		cmd_roll  = c[3];
		cmd_pitch = c[4];
		cmd_yaw   = c[5];
		in_valid  = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (expected_drives.size() != 0)
			@(negedge clk);
	endtask

	function automatic cmd_set_t axes(int s, int w, int h, int r, int p, int y);
		cmd_set_t c;
		c[0] = s[SW-1:0];
		c[1] = w[SW-1:0];
		c[2] = h[SW-1:0];
		c[3] = r[SW-1:0];
		c[4] = p[SW-1:0];
		c[5] = y[SW-1:0];
		return c;
	endfunction

	function automatic cmd_set_t random_command();
		cmd_set_t c;
		int kind;
		int m;
		kind = $urandom_range(2);
		for (int j = 0; j < N_AXES; j++)
			case (kind)
				0: c[j] = SW'($urandom_range(65535));
				1: c[j] = SW'($urandom_range(32767) - 16384);
				default: begin
					m = int'($urandom_range(2000)) + 20845;
					c[j] = SW'(($urandom_range(1) == 1) ? m : -m);
				end
			endcase
		return c;
	endfunction

	task automatic test_directed();
		cmd_set_t c;
		send_command(axes(0, 0, 0, 0, 0, 0));
		send_command(axes(32767, 32767, 32767, 32767, 32767, 32767));
		send_command(axes(-32768, -32768, -32768, -32768, -32768, -32768));
		for (int j = 0; j < N_AXES; j++) begin
			c = '0;
			c[j] = 16'h7fff;
			send_command(c);
			c[j] = 16'h8000;
			send_command(c);
		end
		// peak exactly one stays unscaled, one step over gets scaled
		send_command(axes(21846, 21845, -21846, -21845, -21845, 21845));
		send_command(axes(21847, 21847, -21847, -21847, -21846, 21846));
		// floor of small negative sums
		send_command(axes(-1, 0, 1, 0, 0, 2));
		send_command(axes(16384, 0, 0, 0, 0, 0));
		send_command({N_AXES{16'h5555}});
		send_command({N_AXES{16'haaaa}});
		wait_drained();
	endtask

	task automatic test_random(input int count);
		for (int n = 0; n < count; n++)
			send_command(random_command());
		wait_drained();
	endtask

	task automatic test_output_holdoff();
		hold_asks++;
		for (int n = 0; n < 40; n++)
			send_command(random_command());
		wait_drained();
	endtask

	task automatic test_drain_pause();
		for (int n = 0; n < 10; n++)
			send_command(random_command());
		wait_drained();
		for (int n = 0; n < 10; n++)
			send_command(random_command());
		wait_drained();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		src_idle_pct = 24;
		dst_idle_pct = 65;
		test_directed();
		test_random(130);

		src_idle_pct = 65;
		dst_idle_pct = 24;
		test_random(130);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		test_random(130);
		test_output_holdoff();
		test_drain_pause();

		repeat (LATENCY + 8) @(negedge clk);
		$display("%0d commands in, %0d drive sets checked: extremes, one-boundary, mixed idling,",
			commands_taken, drive_sets_checked);
		$display("a %0d-cycle output hold-off and a drained pause", HOLD_CYCLES);
		if (drive_mismatches == 0 && expected_drives.size() == 0)
			$display("thruster_mixer_normalized_core regression: pass");
		else
			$display("thruster_mixer_normalized_core regression: fail");
		$finish;
	end

endmodule

/* thruster_mixer_normalized_core.f */
rtl/tmn_pkg.sv
rtl/tmn_lane.sv
rtl/tmn_merge.sv
rtl/tmn_div_step.sv
rtl/thruster_mixer_normalized_core.sv
verif/tb_thruster_mixer_normalized_core.sv
